@@ rtl/asfp_pkg.sv @@
// Package for the ASCII sensor frame parser.
// Holds the frame byte codes, field widths and the result record type.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package asfp_pkg;

    localparam int NUM_CHANNELS   = 5;
    localparam int MAX_DIGITS_DEF = 3;
    localparam int VALUE_W        = 10;
    localparam int BYTE_W         = 8;
    localparam int FIELD_W        = $clog2(NUM_CHANNELS);
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 10;

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'd42;  // '*'
    localparam logic [BYTE_W-1:0] SEP_BYTE   = 8'd44;  // ','
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'd35;  // '#'
    localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'd48;  // '0'
    localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'd57;  // '9'

    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_LEVEL     = 1'd1;

    localparam logic [NUM_CHANNELS-1:0] CHANNEL_ENABLE_RST = 5'd31;
    localparam logic [VALUE_W-1:0]      IDLE_LEVEL_RST     = 10'd500;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'b01,
        ST_FRAME = 2'b10
    } t_state;

    typedef struct packed {
        logic                                 status;
        logic [NUM_CHANNELS-1:0][VALUE_W-1:0] value;
    } t_result;

endpackage

@@ rtl/asfp_parse.sv @@
// Per-byte frame decoder: frame state, field accumulator and held field values.
// Builds the result record when the end byte closes a frame.
// Depends on asfp_pkg.
`timescale 1ns / 1ps

module asfp_parse #(
    parameter int MAX_DIGITS = asfp_pkg::MAX_DIGITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic [asfp_pkg::BYTE_W-1:0]          i_byte,
    input  logic [asfp_pkg::NUM_CHANNELS-1:0]    i_chan_en,
    input  logic [asfp_pkg::VALUE_W-1:0]         i_idle_level,
    output logic                                 o_fire,
    output asfp_pkg::t_result                    o_result
);

    localparam int DIGIT_W = $clog2(MAX_DIGITS + 1);
    localparam int HELD_N  = (asfp_pkg::NUM_CHANNELS > 1) ? asfp_pkg::NUM_CHANNELS - 1 : 1;
    localparam int HW      = (HELD_N > 1) ? $clog2(HELD_N) : 1;
    localparam int VW      = asfp_pkg::VALUE_W;
    localparam int FW      = asfp_pkg::FIELD_W;

    asfp_pkg::t_state r_state, n_state;
    logic [FW-1:0]      r_field, n_field;
    logic [DIGIT_W-1:0] r_digits, n_digits;
    logic [VW-1:0]      r_cur, n_cur;
    logic               r_bad, n_bad;
    logic [VW-1:0]      r_held [HELD_N];
    logic               held_we;

    logic          is_digit;
    logic          last_field;
    logic          end_bad;
    logic [VW-1:0] acc;

    assign is_digit   = (i_byte >= asfp_pkg::DIGIT_LO) && (i_byte <= asfp_pkg::DIGIT_HI);
    assign last_field = (r_field == FW'(asfp_pkg::NUM_CHANNELS - 1));
    assign acc        = (r_cur << 3) + (r_cur << 1) + VW'(i_byte[3:0]);
    assign end_bad    = r_bad || (r_digits == '0) || !last_field;

    always_comb begin
        n_state  = r_state;
        n_field  = r_field;
        n_digits = r_digits;
        n_cur    = r_cur;
        n_bad    = r_bad;
        held_we  = 1'b0;
        o_fire   = 1'b0;
        if (i_en) begin
            priority if (i_byte == asfp_pkg::HDR_BYTE) begin
                n_state  = asfp_pkg::ST_FRAME;
                n_field  = '0;
                n_digits = '0;
                n_cur    = '0;
                n_bad    = 1'b0;
            end else if (r_state != asfp_pkg::ST_FRAME) begin
                n_state = r_state;
            end else if (is_digit) begin
                if (r_digits == DIGIT_W'(MAX_DIGITS)) begin
                    n_bad = 1'b1;
                end else begin
                    n_cur    = acc;
                    n_digits = r_digits + DIGIT_W'(1);
                end
            end else if (i_byte == asfp_pkg::SEP_BYTE) begin
                if (r_digits == '0) n_bad = 1'b1;
                if (last_field) begin
                    n_bad = 1'b1;
                end else begin
                    held_we = 1'b1;
                    n_field = r_field + FW'(1);
                end
                n_digits = '0;
                n_cur    = '0;
            end else if (i_byte == asfp_pkg::END_BYTE) begin
                o_fire   = 1'b1;
                n_state  = asfp_pkg::ST_HUNT;
                n_field  = '0;
                n_digits = '0;
                n_cur    = '0;
                n_bad    = 1'b0;
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.status = end_bad;
        for (int i = 0; i < asfp_pkg::NUM_CHANNELS; i++) begin
            if (end_bad) begin
                o_result.value[i] = '0;
            end else if (!i_chan_en[i]) begin
                o_result.value[i] = i_idle_level;
            end else if (i == asfp_pkg::NUM_CHANNELS - 1) begin
                o_result.value[i] = r_cur;
            end else begin
                o_result.value[i] = r_held[HW'(i)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= asfp_pkg::ST_HUNT;
            r_field  <= '0;
            r_digits <= '0;
            r_cur    <= '0;
            r_bad    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_field  <= n_field;
            r_digits <= n_digits;
            r_cur    <= n_cur;
            r_bad    <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held[r_field[HW-1:0]] <= r_cur;
        end
    end

endmodule

@@ rtl/ascii_sensor_frame_parser_top.sv @@
// Top level of the ASCII sensor frame parser.
// Holds the configuration registers and the result register; uses asfp_parse, asfp_pkg.
`timescale 1ns / 1ps

// One received byte is taken per cycle, every cycle, as long as the result
// register is empty or its item is being taken in the same cycle. A frame is
// '*', five comma-separated decimal fields of one to MAX_DIGITS digits, and
// '#'; a '#' in a frame yields one result item in the cycle after it is taken,
// all other bytes yield none. Status 1 marks a malformed frame, and then every
// sensor value is zero. Disabled channels report the idle level. Register 0
// is the channel enable mask (reset 31), register 1 the idle level (reset 500).

module ascii_sensor_frame_parser_top #(
    parameter int MAX_DIGITS = asfp_pkg::MAX_DIGITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [asfp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [asfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  logic [asfp_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_frame_status,
    output logic [asfp_pkg::VALUE_W-1:0]        o_sensor_one,
    output logic [asfp_pkg::VALUE_W-1:0]        o_sensor_two,
    output logic [asfp_pkg::VALUE_W-1:0]        o_sensor_three,
    output logic [asfp_pkg::VALUE_W-1:0]        o_sensor_four,
    output logic [asfp_pkg::VALUE_W-1:0]        o_sensor_five
);

    logic [asfp_pkg::NUM_CHANNELS-1:0] r_chan_en;
    logic [asfp_pkg::VALUE_W-1:0]      r_idle_level;
    logic                              r_res_valid;
    asfp_pkg::t_result                 r_res;
    asfp_pkg::t_result                 n_res;
    logic                              rx_take;
    logic                              fire;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_take    = i_rx_valid && o_rx_ready;

    asfp_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (rx_take),
        .i_byte       (i_rx_byte),
        .i_chan_en    (r_chan_en),
        .i_idle_level (r_idle_level),
        .o_fire       (fire),
        .o_result     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_en    <= asfp_pkg::CHANNEL_ENABLE_RST;
            r_idle_level <= asfp_pkg::IDLE_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                asfp_pkg::REG_CHANNEL_ENABLE: r_chan_en <= i_cfg_data[asfp_pkg::NUM_CHANNELS-1:0];
                asfp_pkg::REG_IDLE_LEVEL:     r_idle_level <= i_cfg_data[asfp_pkg::VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_frame_status = r_res.status;
    assign o_sensor_one   = r_res.value[0];
    assign o_sensor_two   = r_res.value[1];
    assign o_sensor_three = r_res.value[2];
    assign o_sensor_four  = r_res.value[3];
    assign o_sensor_five  = r_res.value[4];

endmodule

@@ rtl/asfp_checker.sv @@
// Port-level checks for the ASCII sensor frame parser.
// Bound to ascii_sensor_frame_parser_top; depends on asfp_pkg.
`timescale 1ns / 1ps

module asfp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_rx_valid,
    input logic                                o_rx_ready,
    input logic [asfp_pkg::BYTE_W-1:0]         i_rx_byte,
    input logic                                o_res_valid,
    input logic                                i_res_ready,
    input logic                                o_frame_status,
    input logic [asfp_pkg::VALUE_W-1:0]        o_sensor_one,
    input logic [asfp_pkg::VALUE_W-1:0]        o_sensor_two,
    input logic [asfp_pkg::VALUE_W-1:0]        o_sensor_three,
    input logic [asfp_pkg::VALUE_W-1:0]        o_sensor_four,
    input logic [asfp_pkg::VALUE_W-1:0]        o_sensor_five
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_frame_status)
            && $stable(o_sensor_one) && $stable(o_sensor_five))
        else $error("stalled result changed");

    a_new_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !$past(o_res_valid && !i_res_ready)
            |-> $past(i_rx_valid && o_rx_ready && i_rx_byte == asfp_pkg::END_BYTE))
        else $error("result item without a taken end byte");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_status |-> o_sensor_one == '0 && o_sensor_two == '0
            && o_sensor_three == '0 && o_sensor_four == '0 && o_sensor_five == '0)
        else $error("malformed frame with nonzero values");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |-> o_rx_ready)
        else $error("input stalled with empty result register");

endmodule

bind ascii_sensor_frame_parser_top asfp_checker u_asfp_checker (.*);
